/* rtl/cnew_pkg.sv */
// Shared types and constants for the common-neighbor edge weighting core.
// Depends on nothing; imported by the core.
package cnew_pkg;

    localparam int MAX_NODES_DEF = 64;

    localparam int NODE_CNT_W = 7;   // node count, degree and score width
    localparam int ROW_W      = 6;
    localparam int WEIGHT_W   = 16;
    localparam int ADDED_W    = 17;
    localparam int STATUS_W   = 2;
    localparam int Q_W        = 10;  // normalized overlap, Q2.8, at most 2.0
    localparam int FRAC_W     = 8;
    localparam int POP_CHUNK  = 16;  // bitmap bits counted per cycle
    localparam int POP_W      = 5;
    localparam int DIV_STEPS  = 5;   // two quotient bits per step

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DIAG     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ZERO_DEG = 2'd3;

    typedef struct packed {
        logic                action;
        logic [ROW_W-1:0]    row;
        logic [ROW_W-1:0]    col;
        logic [WEIGHT_W-1:0] weight;
    } cmd_word_t;

    typedef struct packed {
        logic [ADDED_W-1:0]    added_weight;
        logic [WEIGHT_W-1:0]   product_weight;
        logic [NODE_CNT_W-1:0] shared_count;
        logic [STATUS_W-1:0]   status;
    } result_word_t;

endpackage

/* rtl/cnew_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module cnew_ram
#(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/common_neighbor_edge_weighting_core.sv */
// Top level of the common-neighbor edge weighting core: sequencer, popcount,
// radix-4 divider and output register. Depends on cnew_pkg and cnew_ram.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------------
//  command  | start / busy       | cmd    (cmd_word_t: action,row,col,weight)
//  result   | done (1-cycle)     | result (result_word_t)
//  config   | cfg_we             | cfg_wdata (node_count, clamped)
//
// A write word reads the bitmap row and then writes it back. A query that
// fails the range or diagonal check answers in the cycle after it is taken.
// Other queries make two bitmap reads on the single read port, run a
// 16-bit-per-cycle popcount of degree and overlap, end with ST_ZERO_DEG if
// the degree is zero and else take five radix-4 divider steps and one
// multiply. Reset clears the bitmap row valid bits at once, so no clearing
// pass is needed; the weight store is never cleared. The result is a one-cycle
// strobe and cannot be stalled; a new word may be taken while it shows.
module common_neighbor_edge_weighting_core
    import cnew_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  cmd_word_t             cmd,
    output logic                  done,
    output result_word_t          result,
    input  logic                  cfg_we,
    input  logic [NODE_CNT_W-1:0] cfg_wdata
);

    localparam int IDX_W   = $clog2(MAX_NODES);
    localparam int WADDR_W = $clog2(MAX_NODES * MAX_NODES);
    localparam int CHUNKS  = (MAX_NODES + POP_CHUNK - 1) / POP_CHUNK;
    localparam int PADW    = CHUNKS * POP_CHUNK;
    localparam int CW      = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int PROD_W  = WEIGHT_W + Q_W;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_WWB  = 8'b0000_0010,  // bitmap write-back
        S_QRJ  = 8'b0000_0100,  // row i arrives, read row j
        S_LOAD = 8'b0000_1000,
        S_CNT  = 8'b0001_0000,
        S_CHK  = 8'b0010_0000,
        S_DIV  = 8'b0100_0000,
        S_MUL  = 8'b1000_0000
    } state_t;

    function automatic logic [POP_W-1:0] pop16(input logic [POP_CHUNK-1:0] v);
        logic [POP_W-1:0] n;
        n = '0;
        for (int k = 0; k < POP_CHUNK; k++)
        begin
            n = n + POP_W'(v[k]);
        end
        return n;
    endfunction

    // one restoring step: returns {quotient bit, new remainder}
    function automatic logic [NODE_CNT_W:0] div_step(
        input logic [NODE_CNT_W-1:0] rem,
        input logic                  b,
        input logic [NODE_CNT_W-1:0] d
    );
        logic [NODE_CNT_W:0] t;
        logic [NODE_CNT_W:0] dd;
        t  = {rem, b};
        dd = {1'b0, d};
        if (t >= dd)
        begin
            return {1'b1, NODE_CNT_W'(t - dd)};
        end
        return {1'b0, t[NODE_CNT_W-1:0]};
    endfunction

    // control state
    state_t                  state_reg, state_next;
    logic [NODE_CNT_W-1:0]   node_count_reg, node_count_next;
    logic [MAX_NODES-1:0]    row_valid_reg, row_valid_next;
    logic                    done_reg, done_next;

    // datapath
    logic [IDX_W-1:0]        row_reg, row_next;
    logic [IDX_W-1:0]        col_reg, col_next;
    logic                    wset_reg, wset_next;
    logic                    rv_reg, rv_next;
    logic [MAX_NODES-1:0]    row_i_reg, row_i_next;
    logic [WEIGHT_W-1:0]     w_reg, w_next;
    logic                    nb_reg, nb_next;
    logic [PADW-1:0]         bits_i_reg, bits_i_next;
    logic [PADW-1:0]         bits_and_reg, bits_and_next;
    logic [CW-1:0]           chunk_reg, chunk_next;
    logic [NODE_CNT_W-1:0]   deg_reg, deg_next;
    logic [NODE_CNT_W-1:0]   com_reg, com_next;
    logic [NODE_CNT_W-1:0]   score_reg, score_next;
    logic [NODE_CNT_W-1:0]   rem_reg, rem_next;
    logic [Q_W-1:0]          dvd_reg, dvd_next;
    logic [Q_W-1:0]          q_reg, q_next;
    logic [2:0]              div_cnt_reg, div_cnt_next;
    result_word_t            result_reg, result_next;

    // memory ports
    logic                    bm_we, bm_re;
    logic [IDX_W-1:0]        bm_waddr, bm_raddr;
    logic [MAX_NODES-1:0]    bm_wdata, bm_rdata;
    logic                    wt_we, wt_re;
    logic [WADDR_W-1:0]      wt_waddr, wt_raddr;
    logic [WEIGHT_W-1:0]     wt_rdata;

    // helpers
    logic                    in_range;
    logic [IDX_W-1:0]        cmd_row_idx, cmd_col_idx;
    logic [WADDR_W-1:0]      cmd_addr;
    logic [MAX_NODES-1:0]    live_mask;
    logic [MAX_NODES-1:0]    row_eff;
    logic [MAX_NODES-1:0]    row_upd;
    logic [NODE_CNT_W:0]     step_hi, step_lo;
    logic [PROD_W-1:0]       prod;
    logic [NODE_CNT_W-1:0]   score_calc;

    cnew_ram #(.WIDTH(MAX_NODES), .DEPTH(MAX_NODES)) u_bitmap_ram (
        .clk   (clk),
        .we    (bm_we),
        .waddr (bm_waddr),
        .wdata (bm_wdata),
        .re    (bm_re),
        .raddr (bm_raddr),
        .rdata (bm_rdata)
    );

    cnew_ram #(.WIDTH(WEIGHT_W), .DEPTH(MAX_NODES * MAX_NODES)) u_weight_ram (
        .clk   (clk),
        .we    (wt_we),
        .waddr (wt_waddr),
        .wdata (cmd.weight),
        .re    (wt_re),
        .raddr (wt_raddr),
        .rdata (wt_rdata)
    );

    assign cmd_row_idx = cmd.row[IDX_W-1:0];
    assign cmd_col_idx = cmd.col[IDX_W-1:0];
    assign cmd_addr    = WADDR_W'(cmd_row_idx) * WADDR_W'(MAX_NODES) + WADDR_W'(cmd_col_idx);
    assign in_range    = (NODE_CNT_W'(cmd.row) < node_count_reg) &&
                         (NODE_CNT_W'(cmd.col) < node_count_reg);

    always_comb
    begin
        for (int k = 0; k < MAX_NODES; k++)
        begin
            live_mask[k] = (NODE_CNT_W'(k) < node_count_reg);
        end
    end

    // a row never written reads as all zero
    assign row_eff = rv_reg ? bm_rdata : '0;

    always_comb
    begin
        row_upd          = row_eff;
        row_upd[col_reg] = wset_reg;
    end

    assign step_hi    = div_step(rem_reg, dvd_reg[Q_W-1], deg_reg);
    assign step_lo    = div_step(step_hi[NODE_CNT_W-1:0], dvd_reg[Q_W-2], deg_reg);
    assign prod       = PROD_W'(w_reg) * PROD_W'(q_reg);
    assign score_calc = nb_reg ? (com_reg + NODE_CNT_W'(1)) : '0;

    assign wt_waddr = cmd_addr;
    assign wt_raddr = cmd_addr;
    assign bm_waddr = row_reg;
    assign bm_wdata = row_upd;

    always_comb
    begin
        state_next      = state_reg;
        node_count_next = node_count_reg;
        row_valid_next  = row_valid_reg;
        done_next       = 1'b0;
        row_next        = row_reg;
        col_next        = col_reg;
        wset_next       = wset_reg;
        rv_next         = rv_reg;
        row_i_next      = row_i_reg;
        w_next          = w_reg;
        nb_next         = nb_reg;
        bits_i_next     = bits_i_reg;
        bits_and_next   = bits_and_reg;
        chunk_next      = chunk_reg;
        deg_next        = deg_reg;
        com_next        = com_reg;
        score_next      = score_reg;
        rem_next        = rem_reg;
        dvd_next        = dvd_reg;
        q_next          = q_reg;
        div_cnt_next    = div_cnt_reg;
        result_next     = result_reg;
        bm_we           = 1'b0;
        bm_re           = 1'b0;
        bm_raddr        = cmd_row_idx;
        wt_we           = 1'b0;
        wt_re           = 1'b0;

        if (cfg_we)
        begin
            node_count_next = (cfg_wdata > NODE_CNT_W'(MAX_NODES)) ?
                              NODE_CNT_W'(MAX_NODES) : cfg_wdata;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    row_next  = cmd_row_idx;
                    col_next  = cmd_col_idx;
                    wset_next = (cmd.weight != '0);
                    rv_next   = row_valid_reg[cmd_row_idx];
                    if (cmd.action == ACT_WRITE)
                    begin
                        if (in_range)
                        begin
                            wt_we      = 1'b1;
                            bm_re      = 1'b1;
                            state_next = S_WWB;
                        end
                    end
                    else if (!in_range)
                    begin
                        done_next   = 1'b1;
                        result_next = '{added_weight: '0, product_weight: '0,
                                        shared_count: '0, status: ST_RANGE};
                    end
                    else if (cmd.row == cmd.col)
                    begin
                        done_next   = 1'b1;
                        result_next = '{added_weight: '0, product_weight: '0,
                                        shared_count: '0, status: ST_DIAG};
                    end
                    else
                    begin
                        bm_re      = 1'b1;
                        wt_re      = 1'b1;
                        state_next = S_QRJ;
                    end
                end
            end
            S_WWB:
            begin
                bm_we                   = 1'b1;
                row_valid_next[row_reg] = 1'b1;
                state_next              = S_IDLE;
            end
            S_QRJ:
            begin
                row_i_next = row_eff & live_mask;
                // weight counts only when j is a neighbor of i
                w_next     = row_eff[col_reg] ? wt_rdata : '0;
                bm_re      = 1'b1;
                bm_raddr   = col_reg;
                rv_next    = row_valid_reg[col_reg];
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                bits_i_next   = PADW'(row_i_reg);
                bits_and_next = PADW'(row_i_reg & row_eff);
                nb_next       = row_i_reg[col_reg];
                chunk_next    = '0;
                deg_next      = '0;
                com_next      = '0;
                state_next    = S_CNT;
            end
            S_CNT:
            begin
                deg_next      = deg_reg + NODE_CNT_W'(pop16(bits_i_reg[POP_CHUNK-1:0]));
                com_next      = com_reg + NODE_CNT_W'(pop16(bits_and_reg[POP_CHUNK-1:0]));
                bits_i_next   = bits_i_reg >> POP_CHUNK;
                bits_and_next = bits_and_reg >> POP_CHUNK;
                chunk_next    = chunk_reg + CW'(1);
                if (chunk_reg == CW'(CHUNKS - 1))
                begin
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (deg_reg == '0)
                begin
                    done_next   = 1'b1;
                    result_next = '{added_weight: '0, product_weight: '0,
                                    shared_count: '0, status: ST_ZERO_DEG};
                    state_next  = S_IDLE;
                end
                else
                begin
                    // score<<8 / deg: the top five dividend bits are already
                    // below deg, so ten quotient bits remain
                    score_next   = score_calc;
                    rem_next     = score_calc >> 2;
                    dvd_next     = {score_calc[1:0], FRAC_W'(0)};
                    q_next       = '0;
                    div_cnt_next = '0;
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                rem_next     = step_lo[NODE_CNT_W-1:0];
                q_next       = {q_reg[Q_W-3:0], step_hi[NODE_CNT_W], step_lo[NODE_CNT_W]};
                dvd_next     = dvd_reg << 2;
                div_cnt_next = div_cnt_reg + 3'd1;
                if (div_cnt_reg == 3'(DIV_STEPS - 1))
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                done_next   = 1'b1;
                result_next = '{added_weight:   ADDED_W'(w_reg) + ADDED_W'(q_reg),
                                product_weight: prod[FRAC_W +: WEIGHT_W],
                                shared_count:   score_reg,
                                status:         ST_OK};
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            node_count_reg <= NODE_CNT_W'(MAX_NODES);
            row_valid_reg  <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            node_count_reg <= node_count_next;
            row_valid_reg  <= row_valid_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg      <= row_next;
        col_reg      <= col_next;
        wset_reg     <= wset_next;
        rv_reg       <= rv_next;
        row_i_reg    <= row_i_next;
        w_reg        <= w_next;
        nb_reg       <= nb_next;
        bits_i_reg   <= bits_i_next;
        bits_and_reg <= bits_and_next;
        chunk_reg    <= chunk_next;
        deg_reg      <= deg_next;
        com_reg      <= com_next;
        score_reg    <= score_next;
        rem_reg      <= rem_next;
        dvd_reg      <= dvd_next;
        q_reg        <= q_next;
        div_cnt_reg  <= div_cnt_next;
        result_reg   <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    // results only leave from the idle state
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while sequencer busy");

    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.action == ACT_WRITE) |=> !done)
        else $error("write word produced a result");

    a_diag_fast: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.action == ACT_QUERY && in_range && cmd.row == cmd.col)
        |=> (done && result.status == ST_DIAG))
        else $error("diagonal query not answered next cycle");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != ST_OK) |->
        (result.added_weight == '0 && result.product_weight == '0 &&
         result.shared_count == '0))
        else $error("error result carries nonzero fields");
`endif

endmodule
